>>> rtl/srtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtg_pkg
// Shared types and constants of the shaped random table generator.
// ----------------------------------------------------------------------------
package srtg_pkg;

	// Shaping modes as stored in the mode register.
	typedef enum logic [2:0] {
		MODE_UNIFORM = 3'd0,
		MODE_LOW     = 3'd1,
		MODE_HIGH    = 3'd2,
		MODE_TRI     = 3'd3,
		MODE_GAUSS   = 3'd4,
		MODE_CAUCHY  = 3'd5
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_SIZE   = 3'd1,
		REG_OFFSET = 3'd2,
		REG_SEED   = 3'd3
	} reg_index_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_MUL,
		ST_CHECK,
		ST_ROM,
		ST_TAN,
		ST_DONE
	} state_t;

	// Generator constants.
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;

	// Tangent table geometry and the code that marks a rejected entry.
	localparam int          TAN_DEPTH  = 16384;
	localparam int          TAN_AW     = 14;
	localparam logic [15:0] TAN_REJECT = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // transaction accepted: apply restart and position wrap
		logic step;    // advance the generator by one draw
		logic first;   // this draw is the first of a set
		logic second;  // this draw is the second of a set
		logic mul;     // register the Gaussian product
		logic finish;  // load the output register and advance the position
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  mid;        // current draw is the midpoint
		logic  gauss_ok;   // Gaussian value within the accepted band
		logic  rom_reject; // tangent entry rejects the draw
		logic  out_busy;   // output register holds a stalled result
	} dp_status_t;

endpackage

>>> rtl/srtg_tan_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtg_tan_rom
// Scaled tangent table with a registered read. Contents are computed once at
// start-up in Q30 fixed point by Taylor series of sine and cosine.
// ----------------------------------------------------------------------------
module srtg_tan_rom (
	input  logic                            clk,
	input  logic [srtg_pkg::TAN_AW-1:0]     addr,
	output logic [15:0]                     rd_data
);

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned GAIN_Q16 = 64'd26986912;

	logic [15:0] tan_table [srtg_pkg::TAN_DEPTH];

	// Unsigned quotient by restoring shift and subtract; the quotient fits in
	// qbits bits.
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den, input int qbits);
		logic [127:0]    rem_w;
		logic [127:0]    den_w;
		longint unsigned q;
		rem_w = {64'd0, num};
		q     = '0;
		for (int i = qbits - 1; i >= 0; i--) begin
			den_w = {64'd0, den} << i;
			if (rem_w >= den_w) begin
				rem_w = rem_w - den_w;
				q     = q | (64'd1 << i);
			end
		end
		return q;
	endfunction

	// Tangent of pi*j/32768 in Q30.
	function automatic longint unsigned tan_q30(input longint unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint          s;
		longint          c;
		longint unsigned ds;
		longint unsigned dc;
		x  = (PI_Q30 * j) >> 15;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		s  = longint'(x);
		c  = longint'(64'd1 << 30);
		for (int n = 1; n <= 10; n++) begin
			ds = longint'((2 * n) * (2 * n + 1));
			dc = longint'((2 * n - 1) * (2 * n));
			// Series terms stay below one in Q30, so 32 quotient bits suffice.
			ts = udiv((ts * x2) >> 30, ds, 32);
			tc = udiv((tc * x2) >> 30, dc, 32);
			if ((n & 1) != 0) begin
				s = s - longint'(ts);
				c = c - longint'(tc);
			end else begin
				s = s + longint'(ts);
				c = c + longint'(tc);
			end
		end
		if (s < 0) s = 0;
		if (c <= 0) c = 1;
		return udiv(longint'(s) << 30, longint'(c), 64);
	endfunction

	// One table entry: gain times tangent, rounded, out-of-band entries marked.
	function automatic logic [15:0] rom_entry(input int m);
		longint unsigned t;
		longint unsigned d;
		longint unsigned mag;
		if (m <= 8192) begin
			t = tan_q30(longint'(m));
		end else begin
			d = tan_q30(longint'(16384 - m));
			t = (d != 0) ? udiv(64'd1 << 60, d, 64) : '1;
		end
		if (t > (64'd100 << 30)) begin
			return srtg_pkg::TAN_REJECT;
		end
		mag = (t * GAIN_Q16 + (64'd1 << 45)) >> 46;
		return (mag > 64'd32768) ? srtg_pkg::TAN_REJECT : mag[15:0];
	endfunction

	// Table contents, filled once before the first clock.
	initial begin
		for (int m = 0; m < srtg_pkg::TAN_DEPTH; m++) begin
			tan_table[m] = rom_entry(m);
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rd_data <= tan_table[addr];
	end

endmodule

>>> rtl/srtg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtg_ctrl
// Controller: sequences draws, the Gaussian product and check, the tangent
// lookup and the output load for one transaction at a time.
// ----------------------------------------------------------------------------
module srtg_ctrl #(
	parameter int GAUSS_DRAWS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  srtg_pkg::dp_status_t status,
	output srtg_pkg::dp_cmd_t    cmd
);

	localparam int CNT_W = (GAUSS_DRAWS > 2) ? $clog2(GAUSS_DRAWS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAUSS_DRAWS - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	srtg_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// State and draw counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtg_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		in_stall   = 1'b1;
		cmd        = '0;
		cmd.first  = (cnt_q == '0);
		cmd.second = (cnt_q == CNT_ONE);
		unique case (state_q)
			srtg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = srtg_pkg::ST_DRAW;
				end
			end
			srtg_pkg::ST_DRAW: begin
				cmd.step = 1'b1;
				unique case (status.mode)
					srtg_pkg::MODE_UNIFORM: state_d = srtg_pkg::ST_DONE;
					srtg_pkg::MODE_LOW, srtg_pkg::MODE_HIGH, srtg_pkg::MODE_TRI: begin
						if (cnt_q == CNT_ONE) begin
							state_d = srtg_pkg::ST_DONE;
						end else begin
							cnt_d = cnt_q + CNT_ONE;
						end
					end
					srtg_pkg::MODE_GAUSS: begin
						if (cnt_q == CNT_LAST) begin
							state_d = srtg_pkg::ST_MUL;
						end else begin
							cnt_d = cnt_q + CNT_ONE;
						end
					end
					srtg_pkg::MODE_CAUCHY: begin
						if (!status.mid) state_d = srtg_pkg::ST_ROM;
					end
					default: state_d = srtg_pkg::ST_DONE;
				endcase
			end
			srtg_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = srtg_pkg::ST_CHECK;
			end
			srtg_pkg::ST_CHECK: begin
				cnt_d   = '0;
				state_d = status.gauss_ok ? srtg_pkg::ST_DONE : srtg_pkg::ST_DRAW;
			end
			srtg_pkg::ST_ROM: begin
				state_d = srtg_pkg::ST_TAN;
			end
			srtg_pkg::ST_TAN: begin
				cnt_d   = '0;
				state_d = status.rom_reject ? srtg_pkg::ST_DRAW : srtg_pkg::ST_DONE;
			end
			srtg_pkg::ST_DONE: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = srtg_pkg::ST_IDLE;
				end
			end
			default: state_d = srtg_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/srtg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtg_datapath
// Datapath: configuration registers, generator state, table position,
// draw capture, Gaussian sum and product, tangent lookup and output register.
// ----------------------------------------------------------------------------
module srtg_datapath #(
	parameter int MAX_TABLE   = 32768,
	parameter int GAUSS_DRAWS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 restart,
	input  srtg_pkg::dp_cmd_t    cmd,
	output srtg_pkg::dp_status_t status,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [24:0]          entry_index,
	output logic signed [15:0]   amplitude,
	output logic                 last_entry
);

	localparam int POS_W    = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
	localparam int SIZE_W   = $clog2(MAX_TABLE + 1);
	localparam int SIZE_RST = (MAX_TABLE < 512) ? MAX_TABLE : 512;
	localparam int SUM_W    = $clog2(GAUSS_DRAWS * 32767 + 1);
	localparam int PROD_W   = SUM_W + 22;
	localparam int A_W      = PROD_W - 20;

	localparam logic signed [PROD_W-1:0] GAUSS_GAIN = PROD_W'(349524);
	localparam logic signed [PROD_W-1:0] GAUSS_RND  = PROD_W'(524288);
	localparam logic signed [SUM_W:0]    GAUSS_MID  = (SUM_W+1)'(GAUSS_DRAWS * 16384);

	srtg_pkg::mode_t mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [9:0]        offset_q;
	logic [31:0]       seed_q;
	logic [31:0]       gen_q;
	logic [POS_W-1:0]  pos_q;
	logic [14:0]       k1_q;
	logic [14:0]       k2_q;
	logic [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic              out_valid_q;
	logic [24:0]       entry_index_q;
	logic [15:0]       amplitude_q;
	logic              last_entry_q;

	logic [31:0]       lcg_next;
	logic [14:0]       draw_k;
	logic [16:0]       size_w;
	logic signed [SUM_W:0] dev;
	logic signed [A_W-1:0] gauss_a;
	logic [14:0]       k1_neg;
	logic [srtg_pkg::TAN_AW-1:0] rom_addr;
	logic [15:0]       rom_data;
	logic signed [17:0] amp_w;
	logic [26:0]       idx_w;
	logic [SIZE_W:0]   pos_inc;
	logic              pos_last;

	// Clamp a table size write into the allowed range.
	always_comb begin
		size_w = {1'b0, cfg_data[15:0]};
		if (size_w == '0) size_w = 17'd1;
		if (size_w > 17'(MAX_TABLE)) size_w = 17'(MAX_TABLE);
	end

	// Configuration registers; the port is always ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= srtg_pkg::MODE_UNIFORM;
			size_q   <= SIZE_W'(SIZE_RST);
			offset_q <= '0;
			seed_q   <= 32'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				srtg_pkg::REG_MODE: begin
					mode_q <= (cfg_data[2:0] > srtg_pkg::MODE_CAUCHY) ? srtg_pkg::MODE_UNIFORM
						: srtg_pkg::mode_t'(cfg_data[2:0]);
				end
				srtg_pkg::REG_SIZE:   size_q   <= SIZE_W'(size_w);
				srtg_pkg::REG_OFFSET: offset_q <= cfg_data[9:0];
				srtg_pkg::REG_SEED:   seed_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// One generator step and the 15-bit draw it yields.
	assign lcg_next = gen_q * srtg_pkg::LCG_MUL + srtg_pkg::LCG_ADD;
	assign draw_k   = lcg_next[30:16];

	// Position bookkeeping for the current entry.
	assign pos_inc  = (SIZE_W+1)'(pos_q) + (SIZE_W+1)'(1);
	assign pos_last = (SIZE_W'(pos_q) == size_q - SIZE_W'(1));

	// Generator state and table position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= 32'd1;
			pos_q <= '0;
		end else begin
			if (cmd.start) begin
				if (restart) gen_q <= seed_q;
				if (restart || SIZE_W'(pos_q) >= size_q) pos_q <= '0;
			end else if (cmd.step) begin
				gen_q <= lcg_next;
			end
			if (cmd.finish) begin
				pos_q <= (pos_inc >= (SIZE_W+1)'(size_q)) ? '0 : POS_W'(pos_inc);
			end
		end
	end

	// Draw capture and Gaussian running sum.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (cmd.first) k1_q <= draw_k;
			if (cmd.second) k2_q <= draw_k;
			sum_q <= cmd.first ? SUM_W'(draw_k) : sum_q + SUM_W'(draw_k);
		end
	end

	// Gaussian product: deviation times gain in Q20, with the rounding term.
	assign dev = $signed({1'b0, sum_q}) - GAUSS_MID;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= $signed({{(PROD_W-SUM_W-1){dev[SUM_W]}}, dev}) * GAUSS_GAIN
				+ GAUSS_RND;
		end
	end

	assign gauss_a = prod_q[PROD_W-1:20];

	// Tangent lookup folded around the midpoint.
	assign k1_neg   = 15'd0 - k1_q;
	assign rom_addr = k1_q[14] ? k1_neg[13:0] : k1_q[13:0];

	srtg_tan_rom u_tan_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	// Status toward the controller.
	always_comb begin
		status.mode       = mode_q;
		status.mid        = (draw_k == 15'd16384);
		status.gauss_ok   = (gauss_a >= -32768) && (gauss_a <= 32768);
		status.rom_reject = (rom_data == srtg_pkg::TAN_REJECT);
		status.out_busy   = out_valid_q && out_stall;
	end

	// Amplitude of the finished entry.
	always_comb begin
		unique case (mode_q)
			srtg_pkg::MODE_UNIFORM: amp_w = $signed({2'b0, k1_q, 1'b0}) - 18'sd32768;
			srtg_pkg::MODE_LOW: begin
				amp_w = $signed({2'b0, ((k2_q < k1_q) ? k2_q : k1_q), 1'b0}) - 18'sd32768;
			end
			srtg_pkg::MODE_HIGH: begin
				amp_w = $signed({2'b0, ((k2_q > k1_q) ? k2_q : k1_q), 1'b0}) - 18'sd32768;
			end
			srtg_pkg::MODE_TRI: begin
				amp_w = $signed({3'b0, k1_q}) + $signed({3'b0, k2_q}) - 18'sd32768;
			end
			srtg_pkg::MODE_GAUSS: begin
				amp_w = (gauss_a > 32767) ? 18'sd32767 : gauss_a[17:0];
			end
			srtg_pkg::MODE_CAUCHY: begin
				if (!k1_q[14]) begin
					amp_w = (rom_data > 16'd32767) ? 18'sd32767 : $signed({2'b0, rom_data});
				end else begin
					amp_w = -$signed({2'b0, rom_data});
				end
			end
			default: amp_w = -18'sd32768;
		endcase
	end

	assign idx_w = 27'(pos_q) + 27'(offset_q) * 27'(size_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			entry_index_q <= idx_w[24:0];
			amplitude_q   <= amp_w[15:0];
			last_entry_q  <= pos_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_index = entry_index_q;
	assign amplitude   = $signed(amplitude_q);
	assign last_entry  = last_entry_q;

endmodule

>>> rtl/shaped_random_table_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shaped_random_table_generator
// Each input transaction yields one table entry: an index and a shaped
// random Q1.15 amplitude drawn from a 32-bit linear congruential generator.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries restart; a transaction is taken when in_valid is
// high and in_stall is low. One transaction is worked on at a time; in_stall
// is low only while the controller is idle. The output channel presents
// entry_index, amplitude and last_entry with out_valid and holds them while
// out_stall is high; a new transaction is still accepted meanwhile and waits
// in its final state until the output register is free.
// The generator takes one step per cycle while the controller draws. Uniform
// mode takes one draw, the two-draw modes two, Gaussian GAUSS_DRAWS draws and
// then the product and its check (a rejected set is drawn anew), and Cauchy
// one draw (repeated on a midpoint draw), the registered table read and its
// check (a rejected tangent entry starts a new draw).
// Configuration writes use cfg_valid, cfg_index and cfg_data; cfg_ready is
// always high. Write only while no transaction is in progress.
// Reset restores mode uniform, size 512, offset 0, seed 1, generator state 1
// and position 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shaped_random_table_generator #(
	parameter int MAX_TABLE   = 32768,
	parameter int GAUSS_DRAWS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [24:0]        entry_index,
	output logic signed [15:0] amplitude,
	output logic               last_entry
);

	srtg_pkg::dp_cmd_t    cmd;
	srtg_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// Controller.
	srtg_ctrl #(
		.GAUSS_DRAWS (GAUSS_DRAWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	srtg_datapath #(
		.MAX_TABLE   (MAX_TABLE),
		.GAUSS_DRAWS (GAUSS_DRAWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.restart     (restart),
		.cmd         (cmd),
		.status      (status),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.entry_index (entry_index),
		.amplitude   (amplitude),
		.last_entry  (last_entry)
	);

endmodule
